@@ hw/rtl/hs_pkg.sv @@
// Shared types and constants for the heap sorter.
// Holds the datapath operation codes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package hs_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FILL,
        OP_BLD_RD,
        OP_LOAD,
        OP_SIFT,
        OP_EXT_RD,
        OP_SWAP,
        OP_ORD,
        OP_OUT
    } hs_op_t;

    typedef struct packed {
        hs_op_t op;
    } hs_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic closing;
        logic single;
        logic sift_done;
        logic par_root;
        logic heap_gt1;
        logic out_fire;
        logic out_last;
    } hs_stat_t;

endpackage

@@ hw/rtl/hs_if.sv @@
// Valid/ready request channels of the heap sorter.
// Depends on hs_pkg for the data width.
`timescale 1ns / 1ps

interface hs_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [hs_pkg::DATA_W-1:0]  value;
    logic                              last_element;

    modport source (output valid, output value, output last_element, input ready);
    modport sink   (input valid, input value, input last_element, output ready);
endinterface

interface hs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [hs_pkg::DATA_W-1:0]  sorted_value;
    logic                              last_value;

    modport source (output valid, output sorted_value, output last_value, input ready);
    modport sink   (input valid, input sorted_value, input last_value, output ready);
endinterface

@@ hw/rtl/hs_datapath.sv @@
// Datapath of the heap sorter: value store, sift unit, index counters.
// Depends on hs_pkg and the channel interfaces in hs_if.sv.
`timescale 1ns / 1ps

module hs_datapath #(
    parameter int MAX_ITEMS = hs_pkg::MAX_ITEMS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  hs_pkg::hs_cmd_t  cmd,
    output hs_pkg::hs_stat_t stat,
    hs_in_if.sink            feed,
    hs_out_if.source         result
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IW = AW + 2;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    logic signed [hs_pkg::DATA_W-1:0] store_mem [MAX_ITEMS];
    logic signed [hs_pkg::DATA_W-1:0] rd_a_reg;
    logic signed [hs_pkg::DATA_W-1:0] rd_b_reg;
    logic signed [hs_pkg::DATA_W-1:0] cur_reg, cur_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] size_reg, size_next;
    logic [CW-1:0] par_reg, par_next;
    logic [AW-1:0] node_reg, node_next;
    logic [AW-1:0] k_reg, k_next;

    logic          in_fire, out_fire, out_last, closing;
    logic [CW-1:0] count_inc, size_m1, par_m1;
    logic [IW-1:0] left_idx, right_idx, child_idx, size_ext;
    logic          left_ok, right_ok, go_left, go_right, move;
    logic signed [hs_pkg::DATA_W-1:0] top_val, child_val;
    logic [AW-1:0] kid_base;
    logic [AW:0]   kid_left, kid_right;
    logic [AW-1:0] ra, rb, wa;
    logic          we;
    logic signed [hs_pkg::DATA_W-1:0] wd;

    assign feed.ready   = (cmd.op == hs_pkg::OP_FILL);
    assign result.valid = (cmd.op == hs_pkg::OP_OUT);
    assign in_fire      = feed.valid && feed.ready;
    assign out_fire     = result.valid && result.ready;

    assign count_inc = count_reg + 1'b1;
    assign size_m1   = size_reg - 1'b1;
    assign par_m1    = par_reg - 1'b1;
    assign closing   = feed.last_element || (count_inc == MAX_CNT);
    assign out_last  = (CW'(k_reg) == (count_reg - 1'b1));

    // One level of the sift: the hole at node_reg takes the larger child if it beats cur_reg.
    assign left_idx  = IW'({node_reg, 1'b1});
    assign right_idx = left_idx + 1'b1;
    assign size_ext  = IW'(size_reg);
    assign left_ok   = left_idx < size_ext;
    assign right_ok  = right_idx < size_ext;
    assign go_left   = left_ok && (rd_a_reg > cur_reg);
    assign top_val   = go_left ? rd_a_reg : cur_reg;
    assign go_right  = right_ok && (rd_b_reg > top_val);
    assign move      = go_left || go_right;
    assign child_idx = go_right ? right_idx : left_idx;
    assign child_val = go_right ? rd_b_reg : rd_a_reg;

    always_comb
    begin
        kid_base = node_reg;
        if (cmd.op == hs_pkg::OP_SIFT)
        begin
            kid_base = child_idx[AW-1:0];
        end
        else if (cmd.op == hs_pkg::OP_SWAP)
        begin
            kid_base = '0;
        end
    end

    assign kid_left  = {kid_base, 1'b1};
    assign kid_right = kid_left + 1'b1;

    always_comb
    begin
        ra = '0;
        rb = '0;
        we = 1'b0;
        wa = '0;
        wd = feed.value;
        unique case (cmd.op)
            hs_pkg::OP_FILL:
            begin
                we = in_fire;
                wa = count_reg[AW-1:0];
                wd = feed.value;
            end
            hs_pkg::OP_BLD_RD:
            begin
                ra = par_m1[AW-1:0];
            end
            hs_pkg::OP_LOAD:
            begin
                ra = kid_left[AW-1:0];
                rb = kid_right[AW-1:0];
            end
            hs_pkg::OP_SIFT:
            begin
                ra = kid_left[AW-1:0];
                rb = kid_right[AW-1:0];
                we = 1'b1;
                wa = node_reg;
                wd = move ? child_val : cur_reg;
            end
            hs_pkg::OP_EXT_RD:
            begin
                rb = size_m1[AW-1:0];
            end
            hs_pkg::OP_SWAP:
            begin
                ra = kid_left[AW-1:0];
                rb = kid_right[AW-1:0];
                we = 1'b1;
                wa = size_m1[AW-1:0];
                wd = rd_a_reg;
            end
            hs_pkg::OP_OUT:
            begin
                ra = out_fire ? (k_reg + 1'b1) : k_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        size_next  = size_reg;
        par_next   = par_reg;
        node_next  = node_reg;
        k_next     = k_reg;
        cur_next   = cur_reg;
        unique case (cmd.op)
            hs_pkg::OP_FILL:
            begin
                if (in_fire)
                begin
                    count_next = count_inc;
                    size_next  = count_inc;
                    par_next   = count_inc >> 1;
                end
            end
            hs_pkg::OP_BLD_RD:
            begin
                node_next = par_m1[AW-1:0];
            end
            hs_pkg::OP_LOAD:
            begin
                cur_next = rd_a_reg;
            end
            hs_pkg::OP_SIFT:
            begin
                if (move)
                begin
                    node_next = child_idx[AW-1:0];
                end
                else
                begin
                    par_next = par_m1;
                end
            end
            hs_pkg::OP_SWAP:
            begin
                cur_next  = rd_b_reg;
                size_next = size_m1;
                node_next = '0;
            end
            hs_pkg::OP_ORD:
            begin
                k_next = '0;
            end
            hs_pkg::OP_OUT:
            begin
                if (out_fire)
                begin
                    k_next = k_reg + 1'b1;
                    if (out_last)
                    begin
                        count_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            size_reg  <= '0;
            par_reg   <= '0;
            node_reg  <= '0;
            k_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            size_reg  <= size_next;
            par_reg   <= par_next;
            node_reg  <= node_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[wa] <= wd;
        end
        rd_a_reg <= store_mem[ra];
        rd_b_reg <= store_mem[rb];
    end

    assign result.sorted_value = rd_a_reg;
    assign result.last_value   = out_last;

    assign stat.in_fire   = in_fire;
    assign stat.closing   = closing;
    assign stat.single    = (count_reg == '0);
    assign stat.sift_done = !move;
    assign stat.par_root  = (par_reg == CW'(1));
    assign stat.heap_gt1  = (size_reg > CW'(1));
    assign stat.out_fire  = out_fire;
    assign stat.out_last  = out_last;

    a_sift_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == hs_pkg::OP_SIFT) |-> (CW'(node_reg) < size_reg))
        else $error("Sift hole lies outside the heap.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("Element count exceeds the store depth.");

    a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == hs_pkg::OP_OUT) |-> (count_reg != '0))
        else $error("Result offered from an empty set.");

endmodule

@@ hw/rtl/hs_ctrl.sv @@
// Controller of the heap sorter: sequences fill, heap build, extraction and output.
// Depends on hs_pkg for the command and status structs.
`timescale 1ns / 1ps

module hs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  hs_pkg::hs_stat_t stat,
    output hs_pkg::hs_cmd_t  cmd
);

    localparam logic [3:0] ST_FILL  = 4'd0;
    localparam logic [3:0] ST_BLD   = 4'd1;
    localparam logic [3:0] ST_LOAD  = 4'd2;
    localparam logic [3:0] ST_BSIFT = 4'd3;
    localparam logic [3:0] ST_EXT   = 4'd4;
    localparam logic [3:0] ST_SWAP  = 4'd5;
    localparam logic [3:0] ST_XSIFT = 4'd6;
    localparam logic [3:0] ST_ORD   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (stat.in_fire && stat.closing)
                begin
                    state_next = stat.single ? ST_ORD : ST_BLD;
                end
            end
            ST_BLD:   state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_BSIFT;
            ST_BSIFT:
            begin
                if (stat.sift_done)
                begin
                    state_next = stat.par_root ? ST_EXT : ST_BLD;
                end
            end
            ST_EXT:   state_next = ST_SWAP;
            ST_SWAP:  state_next = ST_XSIFT;
            ST_XSIFT:
            begin
                if (stat.sift_done)
                begin
                    state_next = stat.heap_gt1 ? ST_EXT : ST_ORD;
                end
            end
            ST_ORD:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (stat.out_fire && stat.out_last)
                begin
                    state_next = ST_FILL;
                end
            end
            default:  state_next = ST_FILL;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_FILL:  cmd.op = hs_pkg::OP_FILL;
            ST_BLD:   cmd.op = hs_pkg::OP_BLD_RD;
            ST_LOAD:  cmd.op = hs_pkg::OP_LOAD;
            ST_BSIFT: cmd.op = hs_pkg::OP_SIFT;
            ST_EXT:   cmd.op = hs_pkg::OP_EXT_RD;
            ST_SWAP:  cmd.op = hs_pkg::OP_SWAP;
            ST_XSIFT: cmd.op = hs_pkg::OP_SIFT;
            ST_ORD:   cmd.op = hs_pkg::OP_ORD;
            ST_OUT:   cmd.op = hs_pkg::OP_OUT;
            default:  cmd.op = hs_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_close_leaves_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && stat.in_fire && stat.closing) |=> (state_reg != ST_FILL))
        else $error("Closing request did not start the sort.");

    a_last_returns_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && stat.out_fire && stat.out_last) |=> (state_reg == ST_FILL))
        else $error("Controller did not return to fill after the final result.");

    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg <= ST_OUT)
        else $error("Controller state holds an unknown code.");

endmodule

@@ hw/rtl/heap_sorter.sv @@
// Top level of the heap sorter: joins the controller and the datapath.
// Depends on hs_pkg, hs_if.sv, hs_ctrl and hs_datapath.
//
// Values arrive on the feed channel (valid/ready) and are stored one per cycle.
// A request with last_element set, or the one that fills the store to
// MAX_ITEMS entries, closes the set; feed.ready then stays low until the whole
// sorted set has left on the result channel. The set is heap sorted in place in
// a single store with one write port and two registered read ports. Each sift
// is set up by a read state (ST_BLD or ST_EXT) and a load or swap state, then
// descends one heap level at a time until no child beats the moving value.
// Results then stream out in ascending order, one per cycle while result.ready
// is high, with last_value set on the largest value. When the receiver stalls,
// the current result holds steady. Reset clears the controller and the
// counters; the store itself is not cleared and needs no clearing pass, so the
// block takes a request right after reset.
`timescale 1ns / 1ps

module heap_sorter #(
    parameter int MAX_ITEMS = hs_pkg::MAX_ITEMS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    hs_in_if.sink    feed,
    hs_out_if.source result
);

    hs_pkg::hs_cmd_t  cmd;
    hs_pkg::hs_stat_t stat;

    hs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    hs_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .feed   (feed),
        .result (result)
    );

endmodule
